// File: rtl/core/lil_pkg.sv
// Package for the indexed list engine.
// Holds the request and response structs, request and status codes,
// and the per-cycle command that drives the row of storage cells.
package lil_pkg;

  localparam int LIL_CAPACITY = 16;

  localparam int TYPE_W  = 3;
  localparam int POS_W   = 6;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;
  localparam int IDX_W   = 7;

  localparam logic [TYPE_W-1:0] REQ_APPEND   = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_PREPEND  = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_INSERT   = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_DELETE   = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_POP_HEAD = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_POP_TAIL = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_DUMP     = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOB   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [TYPE_W-1:0]        req_type;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] element_value;
    logic [COUNT_W-1:0]       element_count;
    logic                     last;
  } rsp_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic [IDX_W-1:0]         pos;
    logic [IDX_W-1:0]         tail;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// File: rtl/core/lil_cell.sv
// One storage cell of the list: holds the element at a fixed position.
// Takes its next value from a neighbor, the request, or the head per command.
// Depends on lil_pkg.
module lil_cell #(
  parameter int IDX = 0
) (
  input  logic                              clk,
  input  lil_pkg::cell_cmd_t                cmd,
  input  logic signed [lil_pkg::DATA_W-1:0] left_data,
  input  logic signed [lil_pkg::DATA_W-1:0] right_data,
  input  logic signed [lil_pkg::DATA_W-1:0] head_data,
  output logic signed [lil_pkg::DATA_W-1:0] data
);
  import lil_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_INSERT: begin
        if (MY_IDX == cmd.pos) begin
          data <= cmd.value;
        end else if (MY_IDX > cmd.pos) begin
          data <= left_data;
        end
      end
      OP_REMOVE: begin
        if (MY_IDX >= cmd.pos) begin
          data <= right_data;
        end
      end
      OP_ROTATE: begin
        if (MY_IDX == cmd.tail) begin
          data <= head_data;
        end else if (MY_IDX < cmd.tail) begin
          data <= right_data;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

// File: rtl/core/indexed_list_engine.sv
// Indexed list engine: a bounded ordered list of signed 32-bit values kept in
// a row of cells, one element per cell; insert and delete shift the cells past
// the position by one place at the edge that takes the request, so append,
// prepend, insert, delete and the pops each answer with one response.
// Dump walks the list by rotating the occupied cells one place per cycle while
// the output register is free, and reading the head cell, giving one response
// per element, or one response alone for an empty list. One request is in
// work at a time; a new request is taken as soon as the last response of the
// previous one is in the output register and that register will be free.
// Depends on lil_pkg and lil_cell.
module indexed_list_engine #(
  parameter int CAPACITY = lil_pkg::LIL_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  lil_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output lil_pkg::rsp_t rsp
);
  import lil_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t                   state;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic [CW-1:0]            remaining;
  logic                     out_free;
  logic                     accept;
  logic                     dump_step;
  logic                     is_ins;
  logic                     is_del;
  logic                     is_dump;
  logic                     start_dump;
  logic [IDX_W-1:0]         cnt_ext;
  logic [IDX_W-1:0]         target;
  logic [STAT_W-1:0]        status;
  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state == S_DUMP) || !out_free;
  assign accept    = req_valid && !req_stall;
  assign dump_step = (state == S_DUMP) && out_free;
  assign cnt_ext   = IDX_W'(count);

  always_comb begin
    is_ins  = 1'b0;
    is_del  = 1'b0;
    is_dump = 1'b0;
    target  = '0;
    case (req.req_type)
      REQ_APPEND: begin
        is_ins = 1'b1;
        target = cnt_ext;
      end
      REQ_PREPEND: begin
        is_ins = 1'b1;
      end
      REQ_INSERT: begin
        is_ins = 1'b1;
        target = IDX_W'(req.position);
      end
      REQ_DELETE: begin
        is_del = 1'b1;
        target = IDX_W'(req.position);
      end
      REQ_POP_HEAD: begin
        is_del = 1'b1;
      end
      REQ_POP_TAIL: begin
        is_del = 1'b1;
        target = cnt_ext - IDX_W'(1);
      end
      REQ_DUMP: begin
        is_dump = 1'b1;
      end
      default: begin
        target = '0;
      end
    endcase
  end

  always_comb begin
    status     = ST_OK;
    count_next = count;
    start_dump = 1'b0;
    cmd.op     = OP_HOLD;
    cmd.pos    = target;
    cmd.tail   = cnt_ext - IDX_W'(1);
    cmd.value  = req.item_value;
    if (dump_step) begin
      cmd.op = OP_ROTATE;
    end else if (accept) begin
      if (is_ins) begin
        if (target > cnt_ext) begin
          status = ST_OOB;
        end else if (count == CW'(CAPACITY)) begin
          status = ST_FULL;
        end else begin
          cmd.op     = OP_INSERT;
          count_next = count + CW'(1);
        end
      end else if (is_del) begin
        if (count == '0) begin
          status = ST_EMPTY;
        end else if (target >= cnt_ext) begin
          status = ST_OOB;
        end else begin
          cmd.op     = OP_REMOVE;
          count_next = count - CW'(1);
        end
      end else if (is_dump) begin
        start_dump = (count != '0);
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_data;
    logic signed [DATA_W-1:0] right_data;
    if (i == 0) begin : g_first
      assign left_data = req.item_value;
    end else begin : g_mid_left
      assign left_data = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_data = cell_data[i];
    end else begin : g_mid_right
      assign right_data = cell_data[i+1];
    end
    lil_cell #(
      .IDX(i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .left_data  (left_data),
      .right_data (right_data),
      .head_data  (cell_data[0]),
      .data       (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      count     <= '0;
      remaining <= '0;
    end else begin
      if (dump_step || (accept && !start_dump)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (dump_step) begin
        remaining <= remaining - CW'(1);
        if (remaining == CW'(1)) begin
          state <= S_IDLE;
        end
      end else if (accept) begin
        count <= count_next;
        if (start_dump) begin
          state     <= S_DUMP;
          remaining <= count;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dump_step) begin
      rsp.status        <= ST_OK;
      rsp.element_value <= cell_data[0];
      rsp.element_count <= COUNT_W'(count);
      rsp.last          <= (remaining == CW'(1));
    end else if (accept && !start_dump) begin
      rsp.status        <= status;
      rsp.element_value <= '0;
      rsp.element_count <= COUNT_W'(count_next);
      rsp.last          <= 1'b1;
    end
  end

endmodule

// File: rtl/core/lil_checker.sv
// Port-level checks for the indexed list engine, bound to its top level.
// Depends on lil_pkg.
module lil_checker #(
  parameter int CAPACITY = lil_pkg::LIL_CAPACITY
) (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input lil_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input lil_pkg::rsp_t rsp
);
  import lil_pkg::*;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.element_count <= COUNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.last && rsp.element_value == '0)
    else $error("error response not a single zero-valued result");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.element_count == COUNT_W'(CAPACITY))
    else $error("full reported below capacity");

  a_dump_blocks: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> req_stall)
    else $error("request taken while a dump is in progress");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

endmodule

bind indexed_list_engine lil_checker #(
  .CAPACITY(CAPACITY)
) u_lil_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// File: bench/indexed_list_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the indexed list engine: watches both channels, keeps a shadow
// copy of the list and compares every response with the predicted one.
// Depends on lil_pkg.
module indexed_list_checker #(
  parameter int CAPACITY = lil_pkg::LIL_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  lil_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  lil_pkg::rsp_t rsp,
  output int            fail_count,
  output int            pending
);
  import lil_pkg::*;

  logic signed [DATA_W-1:0] shadow [CAPACITY];
  int   shadow_len;
  rsp_t due_rsps [$];
  rsp_t want;
  int   errs = 0;

  assign fail_count = errs;

  function automatic rsp_t form_rsp(input logic [STAT_W-1:0] st,
                                    input logic signed [DATA_W-1:0] v,
                                    input logic fin);
    rsp_t r;
    r.status        = st;
    r.element_value = v;
    r.element_count = COUNT_W'(shadow_len);
    r.last          = fin;
    return r;
  endfunction

  task automatic apply_request(input req_t r);
    logic [STAT_W-1:0] st;
    int at;
    int i;
    st = ST_OK;
    at = 0;
    case (r.req_type)
      REQ_APPEND, REQ_PREPEND, REQ_INSERT: begin
        if (r.req_type == REQ_APPEND) at = shadow_len;
        else if (r.req_type == REQ_PREPEND) at = 0;
        else at = int'(r.position);
        if (at > shadow_len) begin
          st = ST_OOB;
        end else if (shadow_len >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          for (i = shadow_len; i > at; i--) shadow[i] = shadow[i-1];
          shadow[at] = r.item_value;
          shadow_len++;
        end
      end
      REQ_DELETE, REQ_POP_HEAD, REQ_POP_TAIL: begin
        if (r.req_type == REQ_DELETE) at = int'(r.position);
        else if (r.req_type == REQ_POP_HEAD) at = 0;
        else at = shadow_len - 1;
        if (shadow_len == 0) begin
          st = ST_EMPTY;
        end else if (at >= shadow_len) begin
          st = ST_OOB;
        end else begin
          for (i = at; i + 1 < shadow_len; i++) shadow[i] = shadow[i+1];
          shadow_len--;
        end
      end
      default: ;
    endcase
    if (r.req_type == REQ_DUMP && shadow_len > 0) begin
      for (i = 0; i < shadow_len; i++)
        due_rsps.push_back(form_rsp(ST_OK, shadow[i], i + 1 == shadow_len));
    end else begin
      due_rsps.push_back(form_rsp(st, '0, 1'b1));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      shadow_len = 0;
      due_rsps.delete();
    end else begin
      if (req_valid && !req_stall) apply_request(req);
      if (rsp_valid && !rsp_stall) begin
        if (due_rsps.size() == 0) begin
          $error("response with none expected: status %0d value %0d count %0d last %0b",
                 rsp.status, rsp.element_value, rsp.element_count, rsp.last);
          errs++;
        end else begin
          want = due_rsps.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            errs++;
          end
          if (rsp.element_value !== want.element_value) begin
            $error("element_value: expected %0d, got %0d",
                   want.element_value, rsp.element_value);
            errs++;
          end
          if (rsp.element_count !== want.element_count) begin
            $error("element_count: expected %0d, got %0d",
                   want.element_count, rsp.element_count);
            errs++;
          end
          if (rsp.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, rsp.last);
            errs++;
          end
        end
      end
    end
    pending <= due_rsps.size();
  end

endmodule

// File: bench/tb_indexed_list_engine.sv
`timescale 1ns / 1ps
// Top of the indexed list engine bench: clock, reset, request and response
// drivers with random idling and one long response hold-off, and the verdict.
// Depends on lil_pkg, indexed_list_engine and indexed_list_checker.
module tb_indexed_list_engine;
  import lil_pkg::*;

  localparam logic [TYPE_W-1:0] REQ_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS   = 258;
  localparam int PHASE_LEN      = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;
  int   fail_count;
  int   pending;
  bit   quiet = 1'b0;
  bit   hold_go = 1'b0;
  bit   held = 1'b0;

  always #4 clk = ~clk;

  indexed_list_engine u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  indexed_list_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic req_t make_req(input logic [TYPE_W-1:0] kind, input int at,
                                    input logic [DATA_W-1:0] v);
    req_t r;
    r.req_type   = kind;
    r.position   = POS_W'(at);
    r.item_value = v;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic req_t pick_request(input bit growing);
    int roll;
    int at;
    logic [TYPE_W-1:0] kind;
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      kind = REQ_UNUSED;
    end else if (roll < 10) begin
      kind = REQ_DUMP;
    end else if (roll < (growing ? 85 : 25)) begin
      case ($urandom_range(0, 2))
        0:       kind = REQ_APPEND;
        1:       kind = REQ_PREPEND;
        default: kind = REQ_INSERT;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       kind = REQ_DELETE;
        1:       kind = REQ_POP_HEAD;
        default: kind = REQ_POP_TAIL;
      endcase
    end
    at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 17);
    return make_req(kind, at, pick_value());
  endfunction

  initial begin
    req_t plan [$];
    int n;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;

    // empty list, unused code, bounds on both sides, extreme values
    plan.push_back(make_req(REQ_DUMP, 0, 32'h0));
    plan.push_back(make_req(REQ_POP_HEAD, 0, 32'h0));
    plan.push_back(make_req(REQ_POP_TAIL, 0, 32'h0));
    plan.push_back(make_req(REQ_DELETE, 0, 32'h0));
    plan.push_back(make_req(REQ_DELETE, 63, 32'hffff_ffff));
    plan.push_back(make_req(REQ_UNUSED, 63, 32'hffff_ffff));
    plan.push_back(make_req(REQ_INSERT, 1, 32'h1234_5678));
    plan.push_back(make_req(REQ_INSERT, 0, 32'h7fff_ffff));
    plan.push_back(make_req(REQ_APPEND, 0, 32'h8000_0000));
    plan.push_back(make_req(REQ_PREPEND, 0, 32'hffff_ffff));
    plan.push_back(make_req(REQ_INSERT, 3, 32'h0));
    plan.push_back(make_req(REQ_INSERT, 63, 32'h5555_5555));
    plan.push_back(make_req(REQ_DELETE, 4, 32'h0));
    plan.push_back(make_req(REQ_DELETE, 63, 32'h0));
    plan.push_back(make_req(REQ_UNUSED, 0, 32'h0));
    plan.push_back(make_req(REQ_DUMP, 0, 32'h0));
    plan.push_back(make_req(REQ_DELETE, 1, 32'h0));
    plan.push_back(make_req(REQ_POP_HEAD, 0, 32'h0));
    plan.push_back(make_req(REQ_POP_TAIL, 0, 32'h0));
    plan.push_back(make_req(REQ_DUMP, 0, 32'h0));
    plan.push_back(make_req(REQ_POP_HEAD, 0, 32'h0));
    plan.push_back(make_req(REQ_DUMP, 0, 32'h0));
    // alternate growing and shrinking phases so the list fills and drains
    for (n = 0; n < RANDOM_ITEMS; n++)
      plan.push_back(pick_request(((n / PHASE_LEN) % 2) == 0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (n = 0; n < plan.size(); n++) begin
      quiet = (n >= 150 && n < 210);
      if (n == 60) hold_go = 1'b1;
      if (!quiet && $urandom_range(0, 99) < 6) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      req       <= plan[n];
      req_valid <= 1'b1;
      @(posedge clk);
      while (req_stall) @(posedge clk);
    end
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      // hold off long enough for the engine to back up into the request side
      if (hold_go && !held) begin
        held = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 6);
    end
  end

  initial begin
    int stale;
    stale = 0;
    while (stale < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stale = 0;
      else stale++;
    end
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/lil_pkg.sv
rtl/core/lil_cell.sv
rtl/core/indexed_list_engine.sv
rtl/core/lil_checker.sv
bench/indexed_list_checker.sv
bench/tb_indexed_list_engine.sv
